/* sv/assert_macros.svh */
// Assertion macros shared by the verification files of the box blur block.
// Depends on nothing; the user supplies clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define AST_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/bbe_pkg.sv */
// Package of the box blur block: controller state type and register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
package bbe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FLUSH,
    ST_START,
    ST_DIV,
    ST_HOLD
  } bbe_state_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

/* sv/box_blur_7x7_edge_normalized.sv */
// An output-producing transaction starts a sweep of its K*K' in-frame neighbors (1 to 49)
// through the row memory, one read per neighbor; the controller then flushes, starts the
// serial divide of SUMW (14) quotient bits and loads the result register. No input
// transaction is taken from the start of the sweep until that load, so the window sweep and
// the divide hold the input; a stalled result register holds the next result until it drains.
// Inputs that produce no output leave the controller idle. Reset is synchronous, active low,
// and loads width 640, height 480, alpha off, with all frame counters at zero.
`timescale 1ns / 1ps
module box_blur_7x7_edge_normalized #(
  parameter int KERNEL_SIZE = 7,
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. tdata: red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // tuser: opcode (0 = pixel, 1 = drain tick).
  input  logic        in_tuser,
  // Result stream. tdata: red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // tlast: frame_last.
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bbe_pkg::*;

  // Geometry. The row memory keeps a ring of row slots; a power of two that
  // covers 3*R+1 rows is enough because the input runs at most 2*R rows ahead
  // of the output row and the window reaches R rows behind it.
  localparam int R     = KERNEL_SIZE / 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int SLOTW = $clog2(3 * R + 1);
  localparam int AW    = SLOTW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int LAGW  = $clog2(R * MAX_WIDTH + R + 1);
  localparam int SUMW  = $clog2(KERNEL_SIZE * KERNEL_SIZE * 255 + 1);
  localparam int CNTW  = $clog2(KERNEL_SIZE * KERNEL_SIZE + 1);

  // Configuration registers.
  logic [11:0] fw_r, fh_r;
  logic        alpha_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= 12'd640;
      fh_r    <= 12'd480;
      alpha_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WIDTH:  fw_r    <= cfg_pwdata[11:0];
        REG_HEIGHT: fh_r    <= cfg_pwdata[11:0];
        REG_ALPHA:  alpha_r <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  logic cfg_restart;
  assign cfg_restart = cfg_wr && (cfg_paddr[3:2] inside {REG_WIDTH, REG_HEIGHT, REG_ALPHA});

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = {20'd0, fw_r};
      REG_HEIGHT: cfg_prdata = {20'd0, fh_r};
      REG_ALPHA:  cfg_prdata = {31'd0, alpha_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize saturates.
  logic [WW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic [LAGW-1:0] lag;

  always_comb begin
    if (fw_r == 12'd0) w_eff = WW'(1);
    else if ({20'd0, fw_r} > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fw_r);
    if (fh_r == 12'd0) h_eff = RW'(1);
    else if ({20'd0, fh_r} > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(fh_r);
  end

  assign lag = LAGW'(R) * LAGW'(w_eff) + LAGW'(R);

  // Frame position counters and the count of stored pixels not yet emitted.
  logic [CW-1:0]   in_col_r, out_col_r;
  logic [RW-1:0]   in_row_r, out_row_r;
  logic [LAGW-1:0] pend_r;

  bbe_state_t state_r, state_nxt;

  logic accept, is_pixel, drop, drain_ok, emit_go, last_nxt;
  logic in_wrap, out_wrap;
  logic [RW-1:0] out_row_adv;

  assign accept   = in_tvalid && in_tready;
  assign is_pixel = (in_tuser == OP_PIXEL);
  assign drop     = (in_row_r >= h_eff);
  assign drain_ok = (in_row_r >= h_eff) && (out_row_r < h_eff);
  assign emit_go  = accept && ((is_pixel && !drop && pend_r == lag) || (!is_pixel && drain_ok));
  assign in_wrap  = (WW'(in_col_r) + WW'(1) == w_eff);
  assign out_wrap = (WW'(out_col_r) + WW'(1) == w_eff);
  assign out_row_adv = out_wrap ? out_row_r + 1'b1 : out_row_r;
  assign last_nxt = !is_pixel && (out_row_adv == h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else if (accept) begin
      if (is_pixel && !drop) begin
        in_col_r <= in_wrap ? '0 : in_col_r + 1'b1;
        if (in_wrap) in_row_r <= in_row_r + 1'b1;
        if (pend_r != lag) pend_r <= pend_r + 1'b1;
      end
      if (emit_go) begin
        if (last_nxt) begin
          // Frame complete: every counter returns to zero.
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          pend_r    <= '0;
        end else begin
          out_col_r <= out_wrap ? '0 : out_col_r + 1'b1;
          out_row_r <= out_row_adv;
        end
      end
    end
  end

  // Window bounds, clipped to the frame.
  logic [RW-1:0] r0, r1;
  logic [RW:0]   r1t;
  logic [CW-1:0] c0, c1;
  logic [WW:0]   c1t;

  always_comb begin
    r0  = (out_row_r >= RW'(R)) ? out_row_r - RW'(R) : '0;
    r1t = (RW+1)'(out_row_r) + (RW+1)'(R);
    r1  = (r1t > (RW+1)'(h_eff - 1'b1)) ? h_eff - 1'b1 : r1t[RW-1:0];
    c0  = (out_col_r >= CW'(R)) ? out_col_r - CW'(R) : '0;
    c1t = (WW+1)'(out_col_r) + (WW+1)'(R);
    c1  = (c1t > (WW+1)'(w_eff - 1'b1)) ? CW'(w_eff - 1'b1) : CW'(c1t);
  end

  logic [RW-1:0] y_r, r1_r, rc_r;
  logic [CW-1:0] x_r, c0_r, c1_r, cc_r;
  logic          last_r;
  logic          rd_last;

  assign rd_last = (y_r == r1_r) && (x_r == c1_r);

  always_ff @(posedge clk) begin
    if (emit_go) begin
      y_r    <= r0;
      x_r    <= c0;
      r1_r   <= r1;
      c0_r   <= c0;
      c1_r   <= c1;
      rc_r   <= out_row_r;
      cc_r   <= out_col_r;
      last_r <= last_nxt;
    end else if (state_r == ST_READ) begin
      if (x_r == c1_r) begin
        x_r <= c0_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // Row memory: one write (incoming pixel) and one read (window sweep) a cycle.
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          mem_we;

  assign mem_we  = accept && is_pixel && !drop;
  assign wr_addr = {in_row_r[SLOTW-1:0], in_col_r};
  assign rd_addr = {y_r[SLOTW-1:0], x_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_tdata;
    rd_data_r <= mem[rd_addr];
  end

  // Accumulate the window as read data returns.
  logic            rd_vld_r, ctr_r;
  logic [SUMW-1:0] sum_r_r, sum_g_r, sum_b_r;
  logic [CNTW-1:0] cnt_r;
  logic [7:0]      alpha_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= (state_r == ST_READ);
    ctr_r <= (y_r == rc_r) && (x_r == cc_r);
    if (emit_go) begin
      sum_r_r <= '0;
      sum_g_r <= '0;
      sum_b_r <= '0;
      cnt_r   <= '0;
    end else if (rd_vld_r) begin
      sum_r_r <= sum_r_r + SUMW'(rd_data_r[7:0]);
      sum_g_r <= sum_g_r + SUMW'(rd_data_r[15:8]);
      sum_b_r <= sum_b_r + SUMW'(rd_data_r[23:16]);
      cnt_r   <= cnt_r + 1'b1;
      if (ctr_r) alpha_c_r <= rd_data_r[31:24];
    end
  end

  // Divide the three sums by the neighbor count.
  logic       div_start, div_done;
  logic [7:0] q_r, q_g, q_b;

  bbe_div #(
    .SUMW(SUMW),
    .CNTW(CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum_r_in (sum_r_r),
    .sum_g_in (sum_g_r),
    .sum_b_in (sum_b_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quo_r    (q_r),
    .quo_g    (q_g),
    .quo_b    (q_b)
  );

  // Output register; the next input transaction may be taken while it waits.
  logic        out_vld_r, out_last_r, out_load;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= {alpha_r ? alpha_c_r : 8'd0, q_b, q_g, q_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Controller.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (emit_go) state_nxt = ST_READ;
      ST_READ:  if (rd_last) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_HOLD;
      ST_HOLD:  if (!out_vld_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_START: div_start = 1'b1;
      ST_HOLD:  out_load  = !out_vld_r || out_tready;
      default:  ;
    endcase
  end

endmodule

/* sv/bbe_div.sv */
// Restoring divider for three color sums by one shared pixel count.
// One quotient bit per cycle; depends on nothing outside this file.
`timescale 1ns / 1ps
module bbe_div #(
  parameter int SUMW = 14,
  parameter int CNTW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SUMW-1:0] sum_r_in,
  input  logic [SUMW-1:0] sum_g_in,
  input  logic [SUMW-1:0] sum_b_in,
  input  logic [CNTW-1:0] divisor,
  output logic            done,
  output logic [7:0]      quo_r,
  output logic [7:0]      quo_g,
  output logic [7:0]      quo_b
);
  localparam int STW = $clog2(SUMW + 1);

  logic [SUMW-1:0] quo_r_r [3];
  logic [CNTW:0]   rem_r   [3];
  logic [CNTW-1:0] dvs_r;
  logic [STW-1:0]  step_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STW'(SUMW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [CNTW:0] t;
    if (start) begin
      quo_r_r[0] <= sum_r_in;
      quo_r_r[1] <= sum_g_in;
      quo_r_r[2] <= sum_b_in;
      for (int i = 0; i < 3; i++) rem_r[i] <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        t = {rem_r[i][CNTW-1:0], quo_r_r[i][SUMW-1]};
        if (t >= {1'b0, dvs_r}) begin
          rem_r[i]   <= t - {1'b0, dvs_r};
          quo_r_r[i] <= {quo_r_r[i][SUMW-2:0], 1'b1};
        end else begin
          rem_r[i]   <= t;
          quo_r_r[i] <= {quo_r_r[i][SUMW-2:0], 1'b0};
        end
      end
    end
  end

  assign done  = done_r;
  assign quo_r = quo_r_r[0][7:0];
  assign quo_g = quo_r_r[1][7:0];
  assign quo_b = quo_r_r[2][7:0];

endmodule

/* sv/bbe_checker.sv */
// Port-level checker for the box blur block, bound to the top level below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);
  `AST_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output dropped while stalled")
  `AST_CLK(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")
  `AST_RAW(a_rst_quiet, !rst_n |=> !out_tvalid, "output valid right after reset")
  `AST_RAW(a_pready, rst_n |-> cfg_pready, "configuration port not ready")
endmodule

bind box_blur_7x7_edge_normalized bbe_checker u_bbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

/* bench/tb_top.sv */
// Self-checking bench for the 7x7 edge-normalized box blur: drives pixel and drain
// transactions, predicts every blurred pixel with a local model and compares them.
// Depends on bbe_pkg and box_blur_7x7_edge_normalized.
`timescale 1ns / 1ps
module tb_top;
  import bbe_pkg::*;

  localparam int RAD       = 3;
  localparam int SLOTS     = 28;
  localparam int MAXW      = 2048;
  localparam int MAXH      = 2048;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic       last;
    logic [31:0] data;
  } blur_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #5 clk = ~clk;

  box_blur_7x7_edge_normalized u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predictor state: a copy of the row ring, the frame counters and the registers.
  pixel_t       rows [SLOTS*MAXW];
  logic [11:0]  width_reg, height_reg;
  logic         alpha_reg;
  int unsigned  in_col, in_row, out_col, out_row;
  blur_result_t blur_queue[$];
  int           mismatch_count = 0;
  int           n_sent = 0;

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAXH) return MAXH;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // Mean of the in-frame neighbors of the next output position, then step that position.
  function automatic blur_result_t blur_next(int unsigned w, int unsigned h);
    blur_result_t res;
    int unsigned  r0, r1, c0, c1, sr, sg, sb, cnt;
    pixel_t       p;
    r0 = (out_row >= RAD) ? out_row - RAD : 0;
    c0 = (out_col >= RAD) ? out_col - RAD : 0;
    r1 = (out_row + RAD > h - 1) ? h - 1 : out_row + RAD;
    c1 = (out_col + RAD > w - 1) ? w - 1 : out_col + RAD;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned y = r0; y <= r1; y++)
      for (int unsigned x = c0; x <= c1; x++) begin
        p = rows[(y % SLOTS)*MAXW + x];
        sr += p.red; sg += p.green; sb += p.blue;
      end
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    p = rows[(out_row % SLOTS)*MAXW + out_col];
    res.data = {alpha_reg ? p.alpha : 8'd0, 8'(sb / cnt), 8'(sg / cnt), 8'(sr / cnt)};
    res.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return res;
  endfunction

  // Applies one accepted transaction to the predictor; pushes the blurred pixel it causes.
  function automatic void predict_blur(logic op, pixel_t px);
    int unsigned  w, h, k;
    blur_result_t res;
    w = eff_w();
    h = eff_h();
    if (op == OP_PIXEL) begin
      if (in_row >= h) return;
      rows[(in_row % SLOTS)*MAXW + in_col] = px;
      k = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (k >= RAD*w + RAD) blur_queue.push_back(blur_next(w, h));
    end else if (in_row >= h && out_row < h) begin
      res = blur_next(w, h);
      if (out_row >= h) begin
        res.last = 1'b1;
        restart_frame();
      end
      blur_queue.push_back(res);
    end
  endfunction

  // Checks each result transaction against the oldest expected blurred pixel.
  always @(posedge clk) begin
    blur_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result data=%h last=%b", out_tdata, out_tlast);
      end else begin
        exp_res = blur_queue.pop_front();
        if (out_tdata !== exp_res.data || out_tlast !== exp_res.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected data=%h last=%b, got data=%h last=%b",
                     exp_res.data, exp_res.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // Receiver: drops ready for a random stall before each result, with stall-free stretches.
  // Ready stays high across a zero stall so it is assigned once per edge.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  bit burst_mode = 1'b0;

  // Sends one transaction after a random gap; the model is updated on acceptance.
  // Valid stays high after acceptance; the next gap or wait_quiet drops it.
  task automatic send_item(logic op, pixel_t px);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_blur(op, px);
    n_sent++;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (blur_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // APB write in setup and access phases; pready is always high.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val[11:0];
    else if (idx == REG_HEIGHT) height_reg = val[11:0];
    else alpha_reg = val[0];
    restart_frame();
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    return pixel_t'($urandom);
  endfunction

  // Whole frame of random pixels, then drain ticks mixed with stray pixels until the last output is out.
  task automatic send_frame(int unsigned w, int unsigned h);
    for (int i = 0; i < w*h; i++) send_item(OP_PIXEL, rand_pixel());
    while (out_row < eff_h() && in_row >= eff_h())
      send_item($urandom_range(0, 7) == 0 ? OP_PIXEL : OP_DRAIN, rand_pixel());
  endtask

  // Directed rows: opcode, pixel, and a typed-in expectation where it is obvious.
  typedef struct {
    logic   op;
    pixel_t px;
    bit     has_exp;
    logic [31:0] exp_data;
    logic   exp_last;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    blur_result_t got;
    width_reg = 12'd640; height_reg = 12'd480; alpha_reg = 1'b0;
    restart_frame();
    foreach (rows[i]) rows[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 1x1 frame: the single pixel is its own mean, alpha passes, last is set on drain.
    write_reg(REG_WIDTH, 32'd1);
    write_reg(REG_HEIGHT, 32'd1);
    write_reg(REG_ALPHA, 32'd1);
    dir_rows.push_back('{OP_DRAIN, 32'h0, 0, 0, 0});           // drain too early
    dir_rows.push_back('{OP_PIXEL, 32'hFFFFFFFF, 0, 0, 0});
    dir_rows.push_back('{OP_PIXEL, 32'h12345678, 0, 0, 0});    // dropped after last pixel
    dir_rows.push_back('{OP_DRAIN, 32'h0, 1, 32'hFFFFFFFF, 1});
    dir_rows.push_back('{OP_DRAIN, 32'h0, 0, 0, 0});           // nothing pending
    dir_rows.push_back('{OP_PIXEL, 32'h00000000, 0, 0, 0});
    dir_rows.push_back('{OP_DRAIN, 32'h0, 1, 32'h00000000, 1});
    dir_rows.push_back('{OP_PIXEL, 32'hA5C3_3C5A, 0, 0, 0});
    dir_rows.push_back('{OP_DRAIN, 32'h0, 1, 32'hA5C3_3C5A, 1});
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].px);
      if (dir_rows[i].has_exp && blur_queue.size() != 0) begin
        got = blur_queue[blur_queue.size()-1];
        if (got.data !== dir_rows[i].exp_data || got.last !== dir_rows[i].exp_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: table row %0d expected %h, predictor gives %h",
                     i, dir_rows[i].exp_data, got.data);
        end
      end
    end
    wait_quiet();

    // Width and height zero act as one; a one-pixel frame whose channels sit at both extremes.
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'hFFFF_F000);
    write_reg(REG_ALPHA, 32'd0);
    send_item(OP_PIXEL, 32'hFF00FF00);
    send_item(OP_DRAIN, 32'h0);
    wait_quiet();

    // Random part: mostly full frames of small sizes, some broken off by register writes.
    while (n_sent < 1150) begin
      int unsigned w, h, n_part;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_ALPHA, $urandom_range(0, 1));
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // Partial frame, then noise; the next write restarts it.
        n_part = $urandom_range(1, w*h);
        for (int unsigned i = 0; i < n_part; i++)
          send_item($urandom_range(0, 5) == 0 ? OP_DRAIN : OP_PIXEL, rand_pixel());
      end else begin
        send_frame(w, h);
      end
      wait_quiet();
    end

    // Oversize width and height saturate; the lag then exceeds a short burst, so
    // neither the pixels nor an early drain tick produce a result.
    write_reg(REG_WIDTH, 32'd4095);
    write_reg(REG_HEIGHT, 32'd4095);
    burst_mode = 1'b1;
    for (int i = 0; i < 64; i++) send_item(OP_PIXEL, rand_pixel());
    send_item(OP_DRAIN, rand_pixel());
    wait_quiet();

    if (mismatch_count == 0 && blur_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/bbe_pkg.sv
sv/bbe_div.sv
sv/box_blur_7x7_edge_normalized.sv
sv/bbe_checker.sv
bench/tb_top.sv
